// ===== src/target_bearing_and_range_core_assert.svh =====
// Assertion macros for the bearing and range core.
// Used by the top level; no dependencies.
`ifndef TARGET_BEARING_AND_RANGE_CORE_ASSERT_SVH
`define TARGET_BEARING_AND_RANGE_CORE_ASSERT_SVH
`define TBR_ASSERT_IMPL(lbl, clk, rst, a, c) \
lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error("lbl");
`define TBR_ASSERT_NEXT(lbl, clk, rst, a, c) \
lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error("lbl");
`endif

// ===== src/tbr_pkg.sv =====
// Types and constants for the bearing and range core.
// No dependencies.
`default_nettype none
package tbr_pkg;
   localparam int MaxStages = 24;
   localparam logic signed [15:0] AngPi = 16'sd25736;
   localparam logic signed [15:0] AngHalfPi = 16'sd12868;
   localparam logic signed [17:0] Ang2Pi = 18'sd51472;
   localparam logic signed [27:0] ZPi = 28'sd52707179;
   localparam logic signed [27:0] ZHalfPi = 28'sd26353589;
   localparam logic signed [31:0] InvGain = 32'sd652032875;
   localparam logic [0:0] CsrFiringRange = 1'b0;
   localparam logic [0:0] CsrAxisTol = 1'b1;
   localparam logic [1:0] SelVector = 2'd0;
   localparam logic [1:0] SelUp = 2'd1;
   localparam logic [1:0] SelDown = 2'd2;
   localparam logic [1:0] SelZero = 2'd3;

   function automatic logic signed [27:0] atan_entry(input int i);
      logic signed [27:0] t [MaxStages];
      t = '{28'sd13176795, 28'sd7778716, 28'sd4110060, 28'sd2086331, 28'sd1047214,
            28'sd524117, 28'sd262123, 28'sd131069, 28'sd65536, 28'sd32768, 28'sd16384,
            28'sd8192, 28'sd4096, 28'sd2048, 28'sd1024, 28'sd512, 28'sd256, 28'sd128,
            28'sd64, 28'sd32, 28'sd16, 28'sd8, 28'sd4, 28'sd2};
      return t[i];
   endfunction
endpackage
`default_nettype wire

// ===== src/tbr_stream_if.sv =====
// Valid/ready stream interface with a parameterized payload.
// No dependencies.
`default_nettype none
interface tbr_stream_if #(parameter int Width = 1);
   logic valid;
   logic ready;
   logic [Width-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== src/target_bearing_and_range_core.sv =====
// Top level: pipelined distance, bearing, turn and firing offset.
// Depends on tbr_pkg, tbr_stream_if and the assertion header.
//
// channel  dir  payload
// req      in   tank_x, tank_y, target_x, target_y, heading (80 bits)
// rsp      out  distance, range_gap, bearing, turn, offset_x, offset_y (103 bits)
// csr      in   index 0 firing_range, index 1 axis_tolerance
// One transaction per cycle while rsp is not stalled; the request passes through the
// 17-stage square root beside the vectoring CORDIC, then the rotating CORDIC, multiply
// and rounding.
// Synchronous reset clears all valid bits and firing_range and sets axis_tolerance to 1.
// A stall at rsp freezes the whole pipeline and drops req ready.
`default_nettype none
`include "target_bearing_and_range_core_assert.svh"
module target_bearing_and_range_core #(
   parameter int CORDIC_STAGES = 16
) (
   input  wire logic clock,
   input  wire logic reset,
   tbr_stream_if.sink   req,
   tbr_stream_if.source rsp,
   input  wire logic        csr_we,
   input  wire logic [0:0]  csr_index,
   input  wire logic [15:0] csr_wdata
);
   localparam int N = (CORDIC_STAGES < tbr_pkg::MaxStages) ? CORDIC_STAGES
                                                           : tbr_pkg::MaxStages;
   localparam int SQ = 17;            // root bits
   localparam int C = (N + 1 > SQ + 2) ? N + 1 : SQ + 2; // bearing meets root
   localparam int PD = C - SQ - 1;    // root pad depth
   localparam int ZD = C - 1 - N;     // angle pad depth
   localparam int D = C + N + 4;      // pipeline depth

   logic [15:0] firing_range_ff;
   logic [9:0]  axis_tol_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         firing_range_ff <= '0;
         axis_tol_ff <= 10'd1;
      end else if (csr_we) begin
         unique case (csr_index)
            tbr_pkg::CsrFiringRange: firing_range_ff <= csr_wdata;
            tbr_pkg::CsrAxisTol: axis_tol_ff <= csr_wdata[9:0];
            default: ;
         endcase
      end
   end

   logic adv;
   logic [D-1:0] v_ff;
   assign adv = !v_ff[D-1] || rsp.ready;
   assign req.ready = adv;
   always_ff @(posedge clock) begin
      if (reset) v_ff <= '0;
      else if (adv) v_ff <= {v_ff[D-2:0], req.valid};
   end

   // stage 0: differences
   logic signed [16:0] dx0_ff, dy0_ff;
   logic signed [15:0] hd0_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         dx0_ff <= $signed({req.data[47], req.data[47:32]}) -
                   $signed({req.data[79], req.data[79:64]});
         dy0_ff <= $signed({req.data[31], req.data[31:16]}) -
                   $signed({req.data[63], req.data[63:48]});
         hd0_ff <= req.data[15:0];
      end
   end
   // stage 1: squares, decision
   logic [32:0] sq1_ff;
   logic signed [16:0] dx1_ff, dy1_ff;
   logic signed [15:0] hd1_ff;
   logic [1:0] sel1_ff;
   logic [16:0] adx;
   logic [1:0] sel_in;
   logic [32:0] sqsum;
   always_comb begin
      adx = dx0_ff[16] ? 17'(-dx0_ff) : 17'(dx0_ff);
      sqsum = 33'($unsigned(34'(dx0_ff) * 34'(dx0_ff))) +
              33'($unsigned(34'(dy0_ff) * 34'(dy0_ff)));
      if (dx0_ff < 0 && dy0_ff >= 0) sel_in = tbr_pkg::SelVector;
      else if (adx < {7'd0, axis_tol_ff} && dy0_ff > 0) sel_in = tbr_pkg::SelUp;
      else if (adx < {7'd0, axis_tol_ff} && dy0_ff < 0) sel_in = tbr_pkg::SelDown;
      else if (dx0_ff != 0) sel_in = tbr_pkg::SelVector;
      else sel_in = tbr_pkg::SelZero;
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         sq1_ff <= sqsum;
         dx1_ff <= dx0_ff; dy1_ff <= dy0_ff; hd1_ff <= hd0_ff; sel1_ff <= sel_in;
      end
   end

   // square root: SQ stages, restoring, then round
   logic [33:0] srem_ff [SQ+1];
   logic [17:0] sroot_ff [SQ+1];
   logic [33:0] sarg_ff [SQ+1];
   always_comb begin
      srem_ff[0] = '0; sroot_ff[0] = '0; sarg_ff[0] = {1'b0, sq1_ff};
   end
   // vectoring CORDIC runs beside the root; bearing pipe aligned after
   localparam int XW = 40;
   localparam int ZW = 28;
   logic signed [XW-1:0] vx_ff [N+1], vy_ff [N+1];
   logic signed [ZW-1:0] vz_ff [N+1];
   always_comb begin
      vx_ff[0] = dx1_ff[16] ? -(XW'(dx1_ff) <<< 20) : (XW'(dx1_ff) <<< 20);
      vy_ff[0] = dx1_ff[16] ? -(XW'(dy1_ff) <<< 20) : (XW'(dy1_ff) <<< 20);
      vz_ff[0] = !dx1_ff[16] ? '0 : (dy1_ff >= 0 ? tbr_pkg::ZPi : -tbr_pkg::ZPi);
   end
   logic signed [15:0] hdp_ff [SQ+1];
   logic [1:0] selp_ff [SQ+1];
   always_comb begin hdp_ff[0] = hd1_ff; selp_ff[0] = sel1_ff; end
   for (genvar i = 0; i < SQ; i++) begin : g_sqrt
      logic [33:0] r2;
      logic [33:0] trial;
      assign r2 = {srem_ff[i][31:0], sarg_ff[i][33:32]};
      assign trial = {14'd0, sroot_ff[i][17:0], 2'b01};
      always_ff @(posedge clock) begin
         if (adv) begin
            if (r2 >= trial) begin
               srem_ff[i+1] <= r2 - trial;
               sroot_ff[i+1] <= {sroot_ff[i][16:0], 1'b1};
            end else begin
               srem_ff[i+1] <= r2;
               sroot_ff[i+1] <= {sroot_ff[i][16:0], 1'b0};
            end
            sarg_ff[i+1] <= sarg_ff[i] << 2;
            hdp_ff[i+1] <= hdp_ff[i]; selp_ff[i+1] <= selp_ff[i];
         end
      end
   end
   for (genvar i = 0; i < N; i++) begin : g_vec
      always_ff @(posedge clock) begin
         if (adv) begin
            if (vy_ff[i] > 0) begin
               vx_ff[i+1] <= vx_ff[i] + (vy_ff[i] >>> i);
               vy_ff[i+1] <= vy_ff[i] - (vx_ff[i] >>> i);
               vz_ff[i+1] <= vz_ff[i] + tbr_pkg::atan_entry(i);
            end else begin
               vx_ff[i+1] <= vx_ff[i] - (vy_ff[i] >>> i);
               vy_ff[i+1] <= vy_ff[i] + (vx_ff[i] >>> i);
               vz_ff[i+1] <= vz_ff[i] - tbr_pkg::atan_entry(i);
            end
         end
      end
   end
   // delay vectoring angle to meet the root
   logic signed [ZW-1:0] zd_ff [ZD+1];
   always_comb zd_ff[0] = vz_ff[N];
   for (genvar i = 0; i < ZD; i++) begin : g_zd
      always_ff @(posedge clock) if (adv) zd_ff[i+1] <= zd_ff[i];
   end
   // align root: stage A rounding and gap (root index SQ)
   logic [16:0] dist_a_ff;
   logic signed [17:0] gap_a_ff;
   logic signed [15:0] hd_a_ff;
   logic [1:0] sel_a_ff;
   logic [16:0] rroot;
   assign rroot = (srem_ff[SQ] > {16'd0, sroot_ff[SQ]}) ? sroot_ff[SQ][16:0] + 17'd1
                                                          : sroot_ff[SQ][16:0];
   always_ff @(posedge clock) begin
      if (adv) begin
         dist_a_ff <= rroot;
         gap_a_ff <= $signed({1'b0, rroot}) - $signed({2'b0, firing_range_ff});
         hd_a_ff <= hdp_ff[SQ]; sel_a_ff <= selp_ff[SQ];
      end
   end
   // pad stages so vectoring z arrives: PD-1 more
   logic [16:0] dist_p_ff [PD];
   logic signed [17:0] gap_p_ff [PD];
   logic signed [15:0] hd_p_ff [PD];
   logic [1:0] sel_p_ff [PD];
   always_comb begin
      dist_p_ff[0] = dist_a_ff; gap_p_ff[0] = gap_a_ff;
      hd_p_ff[0] = hd_a_ff; sel_p_ff[0] = sel_a_ff;
   end
   for (genvar i = 0; i < PD-1; i++) begin : g_pad
      always_ff @(posedge clock) begin
         if (adv) begin
            dist_p_ff[i+1] <= dist_p_ff[i]; gap_p_ff[i+1] <= gap_p_ff[i];
            hd_p_ff[i+1] <= hd_p_ff[i]; sel_p_ff[i+1] <= sel_p_ff[i];
         end
      end
   end
   // stage B: bearing and turn
   logic signed [ZW-1:0] zr;
   logic signed [15:0] bear_in;
   logic signed [17:0] t;
   always_comb begin
      zr = (zd_ff[ZD] + ZW'(1024)) >>> 11;
      unique case (sel_p_ff[PD-1])
         tbr_pkg::SelVector: bear_in = (zr > ZW'(tbr_pkg::AngPi)) ? tbr_pkg::AngPi :
                         (zr < -ZW'(tbr_pkg::AngPi)) ? -tbr_pkg::AngPi : zr[15:0];
         tbr_pkg::SelUp: bear_in = tbr_pkg::AngHalfPi;
         tbr_pkg::SelDown: bear_in = -tbr_pkg::AngHalfPi;
         default: bear_in = '0;
      endcase
      t = 18'(bear_in) - 18'(hd_p_ff[PD-1]);
      if (t > 18'(tbr_pkg::AngPi)) t = t - tbr_pkg::Ang2Pi;
      else if (t < -18'(tbr_pkg::AngPi)) t = t + tbr_pkg::Ang2Pi;
   end
   logic [16:0] dist_b_ff;
   logic signed [17:0] gap_b_ff;
   logic signed [15:0] bear_b_ff, turn_b_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         dist_b_ff <= dist_p_ff[PD-1]; gap_b_ff <= gap_p_ff[PD-1];
         bear_b_ff <= bear_in; turn_b_ff <= t[15:0];
      end
   end
   // rotating CORDIC
   localparam int RW = 34;
   logic signed [RW-1:0] rx_ff [N+1], ry_ff [N+1];
   logic signed [ZW-1:0] rz_ff [N+1];
   logic rn_ff [N+1];
   logic [16:0] rd_ff [N+1];
   logic signed [17:0] rg_ff [N+1];
   logic signed [15:0] rb_ff [N+1], rt_ff [N+1];
   logic signed [ZW-1:0] z0;
   always_comb begin
      z0 = ZW'(bear_b_ff) <<< 11;
      rx_ff[0] = RW'(tbr_pkg::InvGain); ry_ff[0] = '0;
      if (z0 > tbr_pkg::ZHalfPi) begin rz_ff[0] = z0 - tbr_pkg::ZPi; rn_ff[0] = 1'b1; end
      else if (z0 < -tbr_pkg::ZHalfPi) begin
         rz_ff[0] = z0 + tbr_pkg::ZPi; rn_ff[0] = 1'b1;
      end else begin rz_ff[0] = z0; rn_ff[0] = 1'b0; end
      rd_ff[0] = dist_b_ff; rg_ff[0] = gap_b_ff; rb_ff[0] = bear_b_ff; rt_ff[0] = turn_b_ff;
   end
   for (genvar i = 0; i < N; i++) begin : g_rot
      always_ff @(posedge clock) begin
         if (adv) begin
            if (rz_ff[i] >= 0) begin
               rx_ff[i+1] <= rx_ff[i] - (ry_ff[i] >>> i);
               ry_ff[i+1] <= ry_ff[i] + (rx_ff[i] >>> i);
               rz_ff[i+1] <= rz_ff[i] - tbr_pkg::atan_entry(i);
            end else begin
               rx_ff[i+1] <= rx_ff[i] + (ry_ff[i] >>> i);
               ry_ff[i+1] <= ry_ff[i] - (rx_ff[i] >>> i);
               rz_ff[i+1] <= rz_ff[i] + tbr_pkg::atan_entry(i);
            end
            rn_ff[i+1] <= rn_ff[i]; rd_ff[i+1] <= rd_ff[i]; rg_ff[i+1] <= rg_ff[i];
            rb_ff[i+1] <= rb_ff[i]; rt_ff[i+1] <= rt_ff[i];
         end
      end
   end
   // stage M: multiply; stage O: round and clamp
   logic signed [51:0] mx_ff, my_ff;
   logic [16:0] dm_ff; logic signed [17:0] gm_ff; logic signed [15:0] bm_ff, tm_ff;
   logic signed [RW-1:0] fx, fy;
   assign fx = rn_ff[N] ? -rx_ff[N] : rx_ff[N];
   assign fy = rn_ff[N] ? -ry_ff[N] : ry_ff[N];
   always_ff @(posedge clock) begin
      if (adv) begin
         mx_ff <= 52'(fx) * 52'(rg_ff[N]);
         my_ff <= 52'(fy) * 52'(rg_ff[N]);
         dm_ff <= rd_ff[N]; gm_ff <= rg_ff[N]; bm_ff <= rb_ff[N]; tm_ff <= rt_ff[N];
      end
   end
   function automatic logic signed [17:0] rnd_clamp(input logic signed [51:0] m);
      logic signed [51:0] s;
      s = (m + 52'sd536870912) >>> 30;
      if (s > 52'sd131071) return 18'sd131071;
      if (s < -52'sd131072) return -18'sd131072;
      return s[17:0];
   endfunction
   logic [102:0] out_ff;
   always_ff @(posedge clock) begin
      if (adv) out_ff <= {dm_ff, gm_ff, bm_ff, tm_ff, rnd_clamp(mx_ff), rnd_clamp(my_ff)};
   end
   assign rsp.valid = v_ff[D-1];
   assign rsp.data = out_ff;

   `TBR_ASSERT_IMPL(a_stall_hold, clock, reset, rsp.valid && !rsp.ready, !req.ready)
   `TBR_ASSERT_NEXT(a_out_hold, clock, reset, rsp.valid && !rsp.ready,
                    rsp.valid && $stable(rsp.data))
   `TBR_ASSERT_NEXT(a_tol_reset, clock, 1'b0, reset, axis_tol_ff == 10'd1)
endmodule
`default_nettype wire

// ===== test/tb_target_bearing_and_range_core.sv =====
// Self-checking testbench for target_bearing_and_range_core: random and directed
// position queries with random stalls on both streams, checked by a scoreboard.
// Depends on target_bearing_and_range_core, tbr_pkg and tbr_stream_if from the source folder.
`default_nettype none
module tb_target_bearing_and_range_core;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int Stages = 16;
   localparam int Latency = Stages + 22;
   localparam int IdleLimit = 3000;

   typedef struct packed {
      logic signed [15:0] tank_x;
      logic signed [15:0] tank_y;
      logic signed [15:0] target_x;
      logic signed [15:0] target_y;
      logic signed [15:0] heading;
   } query_type;

   typedef struct packed {
      logic        [16:0] distance;
      logic signed [17:0] range_gap;
      logic signed [15:0] bearing;
      logic signed [15:0] turn;
      logic signed [17:0] offset_x;
      logic signed [17:0] offset_y;
   } answer_type;

   class aim_scoreboard_type;
      answer_type       awaited[$];
      longint           firing_range;
      longint           axis_tol;
      int               errors;
      longint           arctan[24];

      function new();
         arctan = '{13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123,
                    131069, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256,
                    128, 64, 32, 16, 8, 4, 2};
         firing_range = 0;
         axis_tol = 1;
         errors = 0;
      endfunction

      function longint root_rounded(longint s);
         longint r, b;
         r = 0;
         b = 64'sd1 <<< 40;
         while (b > s) b = b >>> 2;
         while (b != 0) begin
            if (s >= r + b) begin
               s = s - (r + b);
               r = (r >>> 1) + b;
            end else begin
               r = r >>> 1;
            end
            b = b >>> 2;
         end
         if (s > r) r = r + 1;
         return r;
      endfunction

      function longint vector_angle(longint dx, longint dy);
         longint x, y, z, xs, ys;
         x = dx * (64'sd1 <<< 20);
         y = dy * (64'sd1 <<< 20);
         z = 0;
         if (dx < 0) begin
            x = -x;
            y = -y;
            z = (dy >= 0) ? 64'sd52707179 : -64'sd52707179;
         end
         for (int i = 0; i < Stages; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0) begin
               x = x + ys; y = y - xs; z = z + arctan[i];
            end else begin
               x = x - ys; y = y + xs; z = z - arctan[i];
            end
         end
         z = (z + 1024) >>> 11;
         if (z > 25736) z = 25736;
         if (z < -25736) z = -25736;
         return z;
      endfunction

      function longint clamp18(longint v);
         if (v > 131071) return 131071;
         if (v < -131072) return -131072;
         return v;
      endfunction

      function void note(query_type q);
         longint dx, dy, adx, span, gap, bear, turn, x, y, z, xs, ys;
         bit neg;
         answer_type a;
         dx = longint'(q.target_x) - longint'(q.tank_x);
         dy = longint'(q.target_y) - longint'(q.tank_y);
         adx = dx < 0 ? -dx : dx;
         span = root_rounded(dx * dx + dy * dy);
         gap = span - firing_range;
         if (dx < 0 && dy >= 0) bear = vector_angle(dx, dy);
         else if (adx < axis_tol && dy > 0) bear = 12868;
         else if (adx < axis_tol && dy < 0) bear = -12868;
         else if (dx < 0 && dy < 0) bear = vector_angle(dx, dy);
         else if (dx > 0) bear = vector_angle(dx, dy);
         else bear = 0;
         turn = bear - longint'(q.heading);
         if (turn > 25736) turn = turn - 51472;
         else if (turn < -25736) turn = turn + 51472;
         z = bear * 2048;
         x = 652032875;
         y = 0;
         neg = 0;
         if (z > 26353589) begin
            z = z - 52707179; neg = 1;
         end else if (z < -26353589) begin
            z = z + 52707179; neg = 1;
         end
         for (int i = 0; i < Stages; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
               x = x - ys; y = y + xs; z = z - arctan[i];
            end else begin
               x = x + ys; y = y - xs; z = z + arctan[i];
            end
         end
         if (neg) begin
            x = -x; y = -y;
         end
         a.distance  = span[16:0];
         a.range_gap = gap[17:0];
         a.bearing   = bear[15:0];
         a.turn      = turn[15:0];
         a.offset_x  = 18'(clamp18((x * gap + (64'sd1 <<< 29)) >>> 30));
         a.offset_y  = 18'(clamp18((y * gap + (64'sd1 <<< 29)) >>> 30));
         awaited.push_back(a);
      endfunction

      function void check(answer_type got);
         answer_type e;
         if (awaited.size() == 0) begin
            $display("%0t: unexpected result %h", $time, got);
            errors++;
            return;
         end
         e = awaited.pop_front();
         if (got.distance !== e.distance) begin
            $display("%0t: distance exp %0d got %0d", $time, e.distance, got.distance);
            errors++;
         end
         if (got.range_gap !== e.range_gap) begin
            $display("%0t: range_gap exp %0d got %0d", $time, e.range_gap, got.range_gap);
            errors++;
         end
         if (got.bearing !== e.bearing) begin
            $display("%0t: bearing exp %0d got %0d", $time, e.bearing, got.bearing);
            errors++;
         end
         if (got.turn !== e.turn) begin
            $display("%0t: turn exp %0d got %0d", $time, e.turn, got.turn);
            errors++;
         end
         if (got.offset_x !== e.offset_x) begin
            $display("%0t: offset_x exp %0d got %0d", $time, e.offset_x, got.offset_x);
            errors++;
         end
         if (got.offset_y !== e.offset_y) begin
            $display("%0t: offset_y exp %0d got %0d", $time, e.offset_y, got.offset_y);
            errors++;
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic csr_we = 0;
   logic [0:0] csr_index = tbr_pkg::CsrFiringRange;
   logic [15:0] csr_wdata = 0;

   tbr_stream_if #(.Width(80))  req_if();
   tbr_stream_if #(.Width(103)) rsp_if();

   target_bearing_and_range_core #(.CORDIC_STAGES(Stages)) DUT (
      .clock(clock), .reset(reset), .req(req_if), .rsp(rsp_if),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   aim_scoreboard_type sb = new();
   bit calm = 0;
   bit long_hold = 0;
   int idle_cycles = 0;

   initial begin
      req_if.valid = 0;
      req_if.data = '0;
      rsp_if.ready = 0;
   end

   always #10 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && req_if.valid && req_if.ready) sb.note(query_type'(req_if.data));
      if (!reset && rsp_if.valid && rsp_if.ready) sb.check(answer_type'(rsp_if.data));
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // drain side: random stalls, with one long hold when asked
   initial begin
      int w;
      @(negedge reset);
      forever begin
         if (long_hold) begin
            long_hold = 0;
            w = 400;
         end else begin
            w = calm ? 0 : $urandom_range(0, 15);
         end
         if (w > 0) begin
            rsp_if.ready <= 0;
            repeat (w) @(posedge clock);
         end
         rsp_if.ready <= 1;
         @(posedge clock);
         while (!rsp_if.valid) @(posedge clock);
      end
   end

   task automatic send_query(input query_type q);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
         req_if.valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid <= 1;
      req_if.data <= q;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
   endtask

   task automatic set_registers(input logic [15:0] rng, input logic [9:0] tol);
      csr_we <= 1;
      csr_index <= tbr_pkg::CsrFiringRange;
      csr_wdata <= rng;
      @(posedge clock);
      csr_index <= tbr_pkg::CsrAxisTol;
      csr_wdata <= {6'd0, tol};
      @(posedge clock);
      csr_we <= 0;
      sb.firing_range = rng;
      sb.axis_tol = tol;
   endtask

   task automatic drain();
      req_if.valid <= 0;
      @(posedge clock);
      while (sb.awaited.size() != 0) @(posedge clock);
      repeat (Latency + 5) @(posedge clock);
   endtask

   function automatic query_type near(input logic signed [15:0] dxv,
                                      input logic signed [15:0] dyv,
                                      input logic signed [15:0] hd);
      query_type q;
      q.tank_x = 16'($urandom_range(0, 16000) - 8000);
      q.tank_y = 16'($urandom_range(0, 16000) - 8000);
      q.target_x = q.tank_x + dxv;
      q.target_y = q.tank_y + dyv;
      q.heading = hd;
      return q;
   endfunction

   function automatic query_type random_query(input int tol);
      query_type q;
      int mode;
      mode = $urandom_range(0, 9);
      if (mode < 5) begin
         q = 80'({$urandom, $urandom, $urandom});
      end else if (mode < 7) begin
         q = near(16'($urandom_range(0, 2 * tol + 4) - tol - 2),
                  16'($urandom_range(0, 4000) - 2000), 16'($urandom));
      end else if (mode < 8) begin
         q = near(16'($urandom_range(0, 4000) - 2000), 16'($urandom_range(0, 4) - 2),
                  16'($urandom));
      end else begin
         q = near(16'($urandom_range(0, 600) - 300), 16'($urandom_range(0, 600) - 300),
                  16'($urandom));
      end
      return q;
   endfunction

   initial begin
      logic [15:0] rng_set [6];
      logic [9:0]  tol_set [6];
      query_type q;
      repeat (9) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      rng_set = '{16'd0, 16'd65535, 16'd1000, 16'd0, 16'd300, 16'd40000};
      tol_set = '{10'd1, 10'd1023, 10'd0, 10'd5, 10'd1, 10'd200};
      for (int p = 0; p < 6; p++) begin
         if (p == 2) rng_set[p] = 16'($urandom);
         set_registers(rng_set[p], tol_set[p]);
         calm = (p == 3);
         if (p == 0 || p == 2) begin
            send_query('{0, 0, 0, 0, 0});
            send_query('{-32768, -32768, 32767, 32767, 32767});
            send_query('{32767, 32767, -32768, -32768, -32768});
            send_query('{32767, -32768, -32768, 32767, 0});
            send_query('{-32768, 32767, 32767, -32768, 0});
            send_query('{100, 100, 100, 500, -32768});
            send_query('{100, 100, 100, -500, 32767});
            send_query('{100, 100, -400, 100, 0});
            send_query('{100, 100, 600, 100, 0});
            send_query('{0, 0, -5, -3000, 0});
            send_query('{0, 0, -5, 3000, 0});
            send_query('{0, 0, 1, 7, 25000});
            send_query('{0, 0, -1, -7, -25000});
            send_query('{0, 0, -20000, -1, 30000});
            send_query('{0, 0, -20000, 1, -30000});
            send_query('{5, 5, 5, 5, 32767});
            send_query('{-32768, 0, 32767, 0, -32768});
            send_query('{0, -32768, 0, 32767, 12868});
         end
         for (int n = 0; n < 300; n++) begin
            if (p == 4 && n == 20) long_hold = 1;
            q = random_query(tol_set[p]);
            send_query(q);
         end
         drain();
      end
      if (sb.errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end
endmodule
`default_nettype wire
